// ===== design/rsag_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsag_pkg
// Shared types and constants of the row scatter-add gradient unit.
// ----------------------------------------------------------------------------
package rsag_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 6;
    localparam int CFG_RW_W     = 7;
    localparam int CFG_SPR_W    = 11;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int CNT_W        = 10;
    localparam int QDEPTH       = 4;
    localparam int QAW          = 2;

    localparam int DEF_MAX_ROW_WIDTH = 64;
    localparam int DEF_MAX_SAMPLES   = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_ROW = 2'd1;

    localparam logic [CFG_RW_W-1:0]  RST_ROW_WIDTH = 7'd64;
    localparam logic [CFG_SPR_W-1:0] RST_SAMPLES   = 11'd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] grad_in;
        logic signed [DATA_W-1:0] sample_index;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] grad_sum;
        logic [POS_W-1:0]         position;
        logic                     row_last;
        logic                     index_error;
    } t_out;

    // classified item handed from front to back
    typedef struct packed {
        logic signed [DATA_W-1:0] grad;
        logic [POS_W-1:0]         addr;
        logic                     add;
        logic                     last;
        logic                     err;
    } t_work;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_READ,
        BK_SHOW
    } t_back_state;

    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return s[DATA_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/rsag_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsag_queue
// Short register queue between the classifying front and the accumulating back.
// ----------------------------------------------------------------------------
module rsag_queue
    import rsag_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_work i_entry,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_work      o_head
);

    t_work            r_q [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QAW:0]     r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/rsag_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsag_front
// Accepts items, checks the index, counts items per row and marks row ends.
// ----------------------------------------------------------------------------
module rsag_front
    import rsag_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire t_in                  i_data,
    output logic                      o_stall,
    input  wire logic [CFG_RW_W-1:0]  i_eff_width,
    input  wire logic [CFG_SPR_W-1:0] i_samples,
    input  wire logic                 i_full,
    output logic                      o_push,
    output t_work                     o_entry
);

    localparam int SW = $clog2(MAX_SAMPLES + 1) > CFG_SPR_W ?
                        $clog2(MAX_SAMPLES + 1) : CFG_SPR_W;

    logic [SW-1:0]    r_cnt;
    logic             r_err;
    logic [SW-1:0]    n_cnt;
    logic             n_err;
    logic [SW-1:0]    eff_samples;
    logic             idx_ok;
    logic             complete;

    always_comb begin
        if (i_samples == '0) begin
            eff_samples = SW'(1);
        end else if (SW'(i_samples) > SW'(MAX_SAMPLES)) begin
            eff_samples = SW'(MAX_SAMPLES);
        end else begin
            eff_samples = SW'(i_samples);
        end
    end

    assign idx_ok = !i_data.sample_index[DATA_W-1]
                  && (i_data.sample_index[DATA_W-2:CFG_RW_W] == '0)
                  && (i_data.sample_index[CFG_RW_W-1:0] < i_eff_width);

    assign complete = !((r_cnt + SW'(1)) < eff_samples);

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_entry.grad = i_data.grad_in;
        o_entry.addr = i_data.sample_index[POS_W-1:0];
        o_entry.add  = idx_ok;
        o_entry.last = complete;
        o_entry.err  = r_err || !idx_ok;
        n_cnt = r_cnt;
        n_err = r_err;
        if (o_push) begin
            n_cnt = complete ? '0 : r_cnt + 1'b1;
            n_err = complete ? 1'b0 : (r_err || !idx_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_err <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_err <= n_err;
        end
    end

endmodule
`default_nettype wire

// ===== design/rsag_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsag_back
// Read-modify-write accumulation into the row store and drain of finished rows.
// ----------------------------------------------------------------------------
module rsag_back
    import rsag_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [CFG_RW_W-1:0] i_eff_width,
    input  wire logic                i_q_valid,
    input  wire t_work               i_q_head,
    output logic                     o_pop,
    output logic                     o_valid,
    output t_out                     o_data,
    input  wire logic                i_stall
);

    localparam int AW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;

    logic [DATA_W-1:0]        r_mem [MAX_ROW_WIDTH];
    logic [MAX_ROW_WIDTH-1:0] r_vld;
    logic [DATA_W-1:0]        r_rd;
    logic                     r_rdv;

    t_back_state      r_state;
    t_back_state      n_state;
    logic [AW-1:0]    r_k;
    logic [AW-1:0]    n_k;
    logic             r_derr;
    logic             n_derr;
    logic             clr;

    logic             r_b_valid;
    t_work            r_b;
    logic             r_fwd_hit;
    logic [DATA_W-1:0] r_fwd_val;

    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] old_val;
    logic [DATA_W-1:0] sum;
    logic              b_we;
    logic              k_last;

    assign o_pop   = (r_state == BK_RUN) && i_q_valid && !(r_b_valid && r_b.last);
    assign rd_addr = (r_state == BK_RUN) ? i_q_head.addr[AW-1:0] : r_k;
    assign old_val = r_fwd_hit ? r_fwd_val : (r_rdv ? r_rd : '0);
    assign sum     = sat_add(old_val, r_b.grad);
    assign b_we    = r_b_valid && r_b.add;
    assign k_last  = ((CFG_RW_W'(r_k) + CFG_RW_W'(1)) == i_eff_width);

    // row store
    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_mem[r_b.addr[AW-1:0]] <= sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd      <= r_mem[rd_addr];
        r_rdv     <= r_vld[rd_addr];
        r_fwd_hit <= b_we && (r_b.addr[AW-1:0] == i_q_head.addr[AW-1:0]);
        r_fwd_val <= sum;
        r_b       <= i_q_head;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (clr) begin
            r_vld <= '0;
        end else if (b_we) begin
            r_vld[r_b.addr[AW-1:0]] <= 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_derr  = r_derr;
        clr     = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            BK_RUN: begin
                if (r_b_valid && r_b.last) begin
                    n_state = BK_READ;
                    n_k     = '0;
                    n_derr  = r_b.err;
                end
            end
            BK_READ: begin
                n_state = BK_SHOW;
            end
            BK_SHOW: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    if (k_last) begin
                        clr     = 1'b1;
                        n_state = BK_RUN;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = BK_READ;
                    end
                end
            end
            default: begin
                n_state = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_RUN;
            r_k       <= '0;
            r_derr    <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_derr    <= n_derr;
            r_b_valid <= o_pop;
        end
    end

    always_comb begin
        o_data.grad_sum    = r_rdv ? r_rd : '0;
        o_data.position    = POS_W'(r_k);
        o_data.row_last    = k_last;
        o_data.index_error = r_derr;
    end

endmodule
`default_nettype wire

// ===== design/row_scatter_add_gradient_unit.sv =====
`default_nettype none
// Flow: an accepted item passes the queue and back stage register to the row
// store; a row's first result follows its last item via BK_READ and BK_SHOW.
// Throughput: 1 item per cycle via the pipelined store read-modify-write with
// forwarding, while no row drains; a finished row drains via BK_READ and BK_SHOW
// per position (registered store read); the full 4-entry queue then stalls input.
// Reset: synchronous active low; store valid bits clear at once, no clearing pass.
// ----------------------------------------------------------------------------
// row_scatter_add_gradient_unit
// Scatter-adds gradients into a row store and emits saturated row sums.
// ----------------------------------------------------------------------------
module row_scatter_add_gradient_unit
    import rsag_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH,
    parameter int MAX_SAMPLES   = DEF_MAX_SAMPLES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire t_in                   i_data,
    output logic                       o_stall,
    output logic                       o_valid,
    output t_out                       o_data,
    input  wire logic                  i_stall,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_RW_W-1:0]  r_row_width;
    logic [CFG_SPR_W-1:0] r_samples;
    logic [CFG_RW_W-1:0]  eff_width;
    logic                 full;
    logic                 push;
    t_work                entry;
    logic                 pop;
    logic                 q_valid;
    t_work                q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= RST_ROW_WIDTH;
            r_samples   <= RST_SAMPLES;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ROW_WIDTH) begin
                r_row_width <= i_cfg_data[CFG_RW_W-1:0];
            end
            if (i_cfg_index == CFG_SAMPLES_PER_ROW) begin
                r_samples <= i_cfg_data[CFG_SPR_W-1:0];
            end
        end
    end

    always_comb begin
        if (r_row_width == '0) begin
            eff_width = CFG_RW_W'(1);
        end else if (r_row_width > CFG_RW_W'(MAX_ROW_WIDTH)) begin
            eff_width = CFG_RW_W'(MAX_ROW_WIDTH);
        end else begin
            eff_width = r_row_width;
        end
    end

    rsag_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .i_eff_width (eff_width),
        .i_samples   (r_samples),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (entry)
    );

    rsag_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    rsag_back #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_eff_width (eff_width),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall)
    );

`ifndef NO_ASSERTIONS
    // positions stay inside the row
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (CFG_RW_W'(o_data.position) < eff_width))
        else $error("position beyond row width");

    // row end flag marks exactly the final position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.row_last ==
                     ((CFG_RW_W'(o_data.position) + CFG_RW_W'(1)) == eff_width)))
        else $error("row_last not on final position");

    // drain walks positions in order
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_data.row_last) |-> ##2
        (o_valid && (o_data.position == POS_W'($past(o_data.position, 2) + 1'b1))))
        else $error("drain position skipped");
`endif

endmodule
`default_nettype wire
